// ===== src/ptcg_pkg.sv =====
`default_nettype none
package ptcg_pkg;

    // Message store geometry
    localparam int MAX_CHARS  = 58;
    localparam int PAGE_CHARS = 29;
    localparam int PRESET_LEN = 16;
    localparam int BUF_AW     = $clog2(MAX_CHARS);

    // Control characters
    localparam logic [7:0] CHAR_CLEAR  = 8'h61;   // 'a'
    localparam logic [7:0] CHAR_PRESET = 8'h2E;   // '.'

    // Drawing constants
    localparam logic [6:0] NONE7       = 7'h7F;   // minus one, nothing shown
    localparam logic [7:0] BLANK       = 8'hFF;
    localparam logic [5:0] SPACE_GLYPH = 6'd26;

    // Register reset values and addresses
    localparam logic [7:0] COLS_RST = 8'd174;
    localparam logic [7:0] REVS_RST = 8'd58;
    localparam logic       REG_COLS = 1'b0;
    localparam logic       REG_REVS = 1'b1;

    // Input kinds
    localparam logic FUNC_CHAR = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // Font: letters A..Z, then space, then digits 0..9; bit low = LED lit
    localparam logic [7:0] FONT [37][6] = '{
        '{8'h40,8'h37,8'h37,8'h37,8'h40,8'hFF}, '{8'h49,8'h36,8'h36,8'h36,8'h00,8'hFF},
        '{8'h5D,8'h3E,8'h3E,8'h3E,8'h41,8'hFF}, '{8'h41,8'h3E,8'h3E,8'h3E,8'h00,8'hFF},
        '{8'h3E,8'h36,8'h36,8'h36,8'h00,8'hFF}, '{8'h3F,8'h37,8'h37,8'h37,8'h00,8'hFF},
        '{8'h59,8'h32,8'h32,8'h36,8'h41,8'hFF}, '{8'h00,8'h77,8'h77,8'h77,8'h00,8'hFF},
        '{8'h3E,8'h1C,8'h00,8'h1C,8'h3E,8'hFF}, '{8'h3F,8'h01,8'h3E,8'h3E,8'h7D,8'hFF},
        '{8'h3E,8'h5D,8'h6B,8'h77,8'h00,8'hFF}, '{8'h7E,8'h7E,8'h7E,8'h7E,8'h00,8'hFF},
        '{8'h00,8'h1F,8'h40,8'h1F,8'h00,8'hFF}, '{8'h00,8'h79,8'h73,8'h47,8'h00,8'hFF},
        '{8'h41,8'h3E,8'h3E,8'h3E,8'h41,8'hFF}, '{8'h4F,8'h37,8'h37,8'h37,8'h40,8'hFF},
        '{8'h7E,8'h41,8'h3E,8'h3E,8'h41,8'hFF}, '{8'h4E,8'h35,8'h33,8'h37,8'h40,8'hFF},
        '{8'h59,8'h36,8'h36,8'h36,8'h4D,8'hFF}, '{8'h3F,8'h3F,8'h00,8'h3F,8'h3F,8'hFF},
        '{8'h01,8'h7E,8'h7E,8'h7E,8'h01,8'hFF}, '{8'h03,8'h7D,8'h7E,8'h7D,8'h03,8'hFF},
        '{8'h01,8'h7E,8'h01,8'h7E,8'h01,8'hFF}, '{8'h1C,8'h6B,8'h77,8'h6B,8'h1C,8'hFF},
        '{8'h1F,8'h6F,8'h70,8'h6F,8'h1F,8'hFF}, '{8'h1C,8'h2E,8'h36,8'h3A,8'h1C,8'hFF},
        '{8'hFF,8'hFF,8'hFF,8'hFF,8'h00,8'h00}, '{8'h00,8'h3E,8'h00,8'hFF,8'h00,8'h00},
        '{8'hFF,8'h00,8'hFF,8'hFF,8'h00,8'h00}, '{8'h06,8'h36,8'h30,8'hFF,8'h00,8'h00},
        '{8'h00,8'h36,8'h36,8'hFF,8'h00,8'h00}, '{8'h00,8'h77,8'h07,8'hFF,8'h00,8'h00},
        '{8'h30,8'h36,8'h06,8'hFF,8'h00,8'h00}, '{8'h30,8'h36,8'h00,8'hFF,8'h00,8'h00},
        '{8'h00,8'h3F,8'h1F,8'hFF,8'h00,8'h00}, '{8'h00,8'h36,8'h00,8'hFF,8'h00,8'h00},
        '{8'h00,8'h36,8'h06,8'hFF,8'h00,8'h00}
    };

    // Preset message
    localparam logic [7:0] PRESET [PRESET_LEN] = '{
        8'h45, 8'h4C, 8'h45, 8'h43, 8'h54, 8'h52, 8'h4F, 8'h4E,
        8'h49, 8'h43, 8'h41, 8'h20, 8'h55, 8'h54, 8'h50, 8'h4C
    };

    // Register configuration
    typedef struct packed {
        logic [7:0] cols;
        logic [7:0] revs;
    } t_cfg;

    // Write request into the message store
    typedef struct packed {
        logic              append;
        logic              preset;
        logic [BUF_AW-1:0] addr;
        logic [7:0]        data;
    } t_buf_wr;

    // Page state after a turn start
    typedef struct packed {
        logic [8:0] rev;
        logic [6:0] hi;
        logic [6:0] lo;
    } t_page;

    // Map a character to its font row
    function automatic logic [5:0] glyph_of(input logic [7:0] ch);
        logic [7:0] t;
        t = 8'h00;
        if (ch >= 8'h41 && ch <= 8'h5A) begin
            t = ch - 8'h41;
            return t[5:0];
        end else if (ch >= 8'h30 && ch <= 8'h39) begin
            t = ch - 8'h30 + 8'd27;
            return t[5:0];
        end
        return SPACE_GLYPH;
    endfunction

    // Revolution count and page latch at the first column of a turn
    function automatic t_page start_page(input logic [8:0] rev, input logic [5:0] cnt,
                                         input logic [7:0] revs, input logic [6:0] hi,
                                         input logic [6:0] lo);
        t_page      p;
        logic [5:0] pg;
        p.rev = rev + 9'd1;
        p.hi  = hi;
        p.lo  = lo;
        pg    = (cnt > 6'(PAGE_CHARS)) ? 6'(PAGE_CHARS) : cnt;
        if (p.rev == 9'd1) begin
            p.hi = {1'b0, pg} - 7'd1;
            p.lo = NONE7;
        end else if (p.rev == {1'b0, revs} + 9'd1) begin
            p.hi = {1'b0, cnt} - 7'd1;
            p.lo = (cnt > 6'(PAGE_CHARS)) ? 7'(PAGE_CHARS - 1) : NONE7;
        end
        if (p.rev >= {revs, 1'b0}) begin
            p.rev = 9'd0;
        end
        return p;
    endfunction

endpackage
`default_nettype wire

// ===== src/ptcg_ram.sv =====
`default_nettype none
module ptcg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 58,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, registered read (old data on collision)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== src/ptcg_msg_buf.sv =====
`default_nettype none
module ptcg_msg_buf (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire ptcg_pkg::t_buf_wr       i_wr,
    input  wire logic [ptcg_pkg::BUF_AW-1:0] i_rd_addr,
    output logic      [7:0]              o_rd_char
);
    import ptcg_pkg::*;

    logic [7:0]            ram_q;
    logic [BUF_AW-1:0]     r_rd_addr;
    logic                  r_fwd;
    logic                  n_fwd;
    logic [7:0]            r_fwd_data;
    logic [PRESET_LEN-1:0] r_ovl;
    logic [PRESET_LEN-1:0] n_ovl;
    logic                  ovl_hit;

    ptcg_ram #(.WIDTH(8), .DEPTH(MAX_CHARS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_wr.append),
        .i_waddr (i_wr.addr),
        .i_wdata (i_wr.data),
        .i_raddr (i_rd_addr),
        .o_rdata (ram_q)
    );

    // Preset overlay: set by a preset load, cleared per entry by an append
    always_comb begin
        n_ovl = r_ovl;
        if (i_wr.preset) begin
            n_ovl = '1;
        end else if (i_wr.append && i_wr.addr < BUF_AW'(PRESET_LEN)) begin
            n_ovl[i_wr.addr[$clog2(PRESET_LEN)-1:0]] = 1'b0;
        end
    end

    // Same-entry write and read in one cycle: forward the write data
    assign n_fwd = i_wr.append && (i_wr.addr == i_rd_addr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovl <= '0;
            r_fwd <= 1'b0;
        end else begin
            r_ovl <= n_ovl;
            r_fwd <= n_fwd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr  <= i_rd_addr;
        r_fwd_data <= i_wr.data;
    end

    // Read data select
    assign ovl_hit = (r_rd_addr < BUF_AW'(PRESET_LEN)) &&
                     r_ovl[r_rd_addr[$clog2(PRESET_LEN)-1:0]];

    always_comb begin
        if (ovl_hit) begin
            o_rd_char = PRESET[r_rd_addr[$clog2(PRESET_LEN)-1:0]];
        end else if (r_fwd) begin
            o_rd_char = r_fwd_data;
        end else begin
            o_rd_char = ram_q;
        end
    end

endmodule
`default_nettype wire

// ===== src/ptcg_col_engine.sv =====
`default_nettype none
module ptcg_col_engine (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire ptcg_pkg::t_cfg              i_cfg,
    input  wire logic [7:0]                  i_revs_nxt,
    // input beats
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic                        i_in_func,
    input  wire logic [7:0]                  i_in_char,
    // result beats
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic      [7:0]                  o_out_led,
    output logic                             o_out_last,
    output logic                             o_out_page,
    // message store
    output ptcg_pkg::t_buf_wr                o_wr,
    output logic      [ptcg_pkg::BUF_AW-1:0] o_rd_addr,
    input  wire logic [7:0]                  i_rd_char
);
    import ptcg_pkg::*;

    logic [5:0] r_cnt, n_cnt;
    logic [6:0] r_hi, n_hi;
    logic [6:0] r_lo, n_lo;
    logic [8:0] r_rev, n_rev;
    logic [7:0] r_col, n_col;
    logic [6:0] r_ptr, n_ptr;
    logic [2:0] r_cig, n_cig;
    logic       r_ovalid, n_ovalid;
    logic [7:0] r_led, n_led;
    logic       r_last, n_last;
    logic       r_page, n_page;

    logic       accept;
    logic       tick;
    logic       col0;
    t_page      sp;
    t_page      nsp;
    logic [6:0] e_hi, e_lo, e_ptr;
    logic [8:0] e_rev;
    logic [2:0] e_cig;
    logic       drawable;
    logic [5:0] g;
    logic [2:0] width;
    logic [2:0] c;
    logic [2:0] c1;
    logic       last;

    assign o_in_ready = !r_ovalid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign tick       = accept && (i_in_func == FUNC_TICK);

    // Effective page state for this beat (turn start applied at column zero)
    assign col0  = (r_col == 8'd0);
    assign sp    = start_page(r_rev, r_cnt, i_cfg.revs, r_hi, r_lo);
    assign e_rev = col0 ? sp.rev : r_rev;
    assign e_hi  = col0 ? sp.hi  : r_hi;
    assign e_lo  = col0 ? sp.lo  : r_lo;
    assign e_ptr = col0 ? sp.hi  : r_ptr;
    assign e_cig = col0 ? 3'd0   : r_cig;

    // Glyph decode of the character under the pointer
    assign drawable = ($signed(e_ptr) > $signed(e_lo)) && !e_ptr[6] &&
                      (e_ptr < 7'(MAX_CHARS));
    assign g     = glyph_of(i_rd_char);
    assign width = (g < SPACE_GLYPH) ? 3'd6 : 3'd4;
    assign c     = (e_cig >= width) ? 3'd0 : e_cig;
    assign c1    = c + 3'd1;
    assign last  = ({1'b0, r_col} + 9'd1) >= {1'b0, i_cfg.cols};

    // Next state for character and tick beats
    always_comb begin
        n_cnt    = r_cnt;
        n_hi     = r_hi;
        n_lo     = r_lo;
        n_rev    = r_rev;
        n_col    = r_col;
        n_ptr    = r_ptr;
        n_cig    = r_cig;
        n_ovalid = r_ovalid && !i_out_ready;
        n_led    = r_led;
        n_last   = r_last;
        n_page   = r_page;
        o_wr     = '{append: 1'b0, preset: 1'b0, addr: r_cnt[BUF_AW-1:0],
                     data: i_in_char};
        if (accept && i_in_func == FUNC_CHAR) begin
            if (i_in_char == CHAR_CLEAR) begin
                n_cnt = 6'd0;
            end else if (i_in_char == CHAR_PRESET) begin
                n_cnt     = 6'(PRESET_LEN);
                o_wr.preset = 1'b1;
            end else if (r_cnt < 6'(MAX_CHARS)) begin
                n_cnt     = r_cnt + 6'd1;
                o_wr.append = 1'b1;
            end
        end
        if (tick) begin
            n_rev = e_rev;
            n_hi  = e_hi;
            n_lo  = e_lo;
            n_ptr = e_ptr;
            n_cig = e_cig;
            n_led = BLANK;
            if (drawable) begin
                n_led = FONT[g][c];
                if (c1 >= width) begin
                    n_cig = 3'd0;
                    n_ptr = e_ptr - 7'd1;
                end else begin
                    n_cig = c1;
                end
            end
            n_col    = last ? 8'd0 : r_col + 8'd1;
            n_ovalid = 1'b1;
            n_last   = last;
            n_page   = (e_lo != NONE7);
        end
    end

    // Prefetch the character the next tick will draw
    assign nsp       = start_page(n_rev, n_cnt, i_revs_nxt, n_hi, n_lo);
    assign o_rd_addr = (n_col == 8'd0) ? nsp.hi[BUF_AW-1:0] : n_ptr[BUF_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= 6'd0;
            r_hi     <= NONE7;
            r_lo     <= NONE7;
            r_rev    <= 9'd0;
            r_col    <= 8'd0;
            r_ptr    <= NONE7;
            r_cig    <= 3'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_cnt    <= n_cnt;
            r_hi     <= n_hi;
            r_lo     <= n_lo;
            r_rev    <= n_rev;
            r_col    <= n_col;
            r_ptr    <= n_ptr;
            r_cig    <= n_cig;
            r_ovalid <= n_ovalid;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        r_led  <= n_led;
        r_last <= n_last;
        r_page <= n_page;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_led   = r_led;
    assign o_out_last  = r_last;
    assign o_out_page  = r_page;

endmodule
`default_nettype wire

// ===== src/pov_text_column_generator_unit.sv =====
`default_nettype none
// Column generator for a rotating LED text display.
// A column tick beat shows its column on the master side in the cycle after it is taken.
// Throughput: one beat per cycle while the master side is not stalled; the message read is prefetched.
// Character beats give no result.
// Reset (synchronous, active low) empties the message and restores both registers.
module pov_text_column_generator_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave side
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_byte
    input  wire logic        s_axis_tuser,   // [0] func
    // master side
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [7:0]  m_axis_tdata,   // [7:0] led_column
    output logic             m_axis_tlast,   // turn_end
    output logic             m_axis_tuser,   // [0] second_page
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import ptcg_pkg::*;

    t_cfg              r_cfg, n_cfg;
    logic              cfg_wr;
    t_buf_wr           wr;
    logic [BUF_AW-1:0] rd_addr;
    logic [7:0]        rd_char;

    // Register writes
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (cfg_wr) begin
            if (paddr[2] == REG_COLS) begin
                n_cfg.cols = pwdata[7:0];
            end else begin
                n_cfg.revs = pwdata[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{cols: COLS_RST, revs: REVS_RST};
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Register reads
    assign prdata = (paddr[2] == REG_REVS) ? {24'd0, r_cfg.revs} : {24'd0, r_cfg.cols};

    ptcg_msg_buf u_msg_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr),
        .i_rd_addr (rd_addr),
        .o_rd_char (rd_char)
    );

    ptcg_col_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_revs_nxt  (n_cfg.revs),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_func   (s_axis_tuser),
        .i_in_char   (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_led   (m_axis_tdata),
        .o_out_last  (m_axis_tlast),
        .o_out_page  (m_axis_tuser),
        .o_wr        (wr),
        .o_rd_addr   (rd_addr),
        .i_rd_char   (rd_char)
    );

endmodule
`default_nettype wire
